// ===== rtl/emgfx_pkg.sv =====
// Package for the EMG feature extractor.
// Holds the item and result types, field widths and code constants.
// Depends on nothing; emgfx_zs, the top level and the testbench import it.
package emgfx_pkg;

  localparam int FILT_W      = 24;
  localparam int FEAT_W      = 49;
  localparam int MEAN_W      = 49;
  localparam int ISIG_W      = 48;
  localparam int Z_W         = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 49;
  localparam int MAX_RESULTS = 48;
  localparam int RES_W       = 6;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TAP    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_EMG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LENGTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MEAN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SIGMA = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] sample_value;
    logic               window_end;
    logic [4:0]         tap_index;
    logic signed [15:0] tap_value;
  } req_t;

  typedef struct packed {
    logic signed [Z_W-1:0] zscore;
    logic                  run_last;
    logic                  clipped;
  } res_t;

  typedef struct packed {
    logic           done;
    logic           clip;
    logic [Z_W-1:0] z;
  } zs_res_t;

endpackage

// ===== rtl/emgfx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the tap table and the sample history. No dependencies.
module emgfx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/emgfx_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Serves the moving-average division. Uses no package items.
module emgfx_div #(
  parameter int NW = 55,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dv;
  logic [DW:0]     tr;
  logic            ge;
  logic [DW:0]     diff;

  assign tr   = {rem, quo[NW-1]};
  assign ge   = tr >= {1'b0, dv};
  assign diff = tr - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNTW'(NW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dv   <= den;
        quo  <= num;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : tr[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/emgfx_zs.sv =====
// Z-score unit: (feature - mean) * inverse sigma, rounded and saturated to Q16.16.
// Four 25x24 partial products over successive cycles. Uses emgfx_pkg.
module emgfx_zs
  import emgfx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [FEAT_W-1:0] feat,
  input  logic signed [MEAN_W-1:0] mean,
  input  logic [ISIG_W-1:0]        isig,
  output zs_res_t                  res
);

  logic signed [49:0] d;
  logic               busy;
  logic [2:0]         step;
  logic [49:0]        a;
  logic [47:0]        b;
  logic               neg;
  logic [48:0]        pp;
  logic [5:0]         psh;
  logic [98:0]        acc;
  logic [24:0]        a_sel;
  logic [23:0]        b_sel;
  logic [5:0]         sh;
  logic [98:0]        rnd;
  logic [82:0]        r;
  logic [82:0]        lim;
  logic               ovf;
  logic [31:0]        qv;

  assign d     = 50'(feat) - 50'(mean);
  assign a_sel = step[1] ? a[49:25] : a[24:0];
  assign b_sel = step[0] ? b[47:24] : b[23:0];
  assign sh    = (step[1] ? 6'd25 : 6'd0) + (step[0] ? 6'd24 : 6'd0);
  assign rnd   = acc + 99'd32768;
  assign r     = rnd[98:16];
  assign lim   = neg ? 83'h80000000 : 83'h7FFFFFFF;
  assign ovf   = r > lim;
  assign qv    = ovf ? lim[31:0] : r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= !start && busy && (step == 3'd5);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        a    <= d[49] ? 50'(-d) : 50'(d);
        neg  <= d[49];
        b    <= isig;
        acc  <= '0;
      end else if (busy) begin
        if (step < 3'd4) begin
          pp  <= a_sel * b_sel;
          psh <= sh;
        end
        if (step != 3'd0 && step <= 3'd4) begin
          acc <= acc + (99'(pp) << psh);
        end
        if (step == 3'd5) begin
          res.clip <= ovf;
          res.z    <= neg ? (32'd0 - qv) : qv;
          busy     <= 1'b0;
        end
        step <= step + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/emg_feature_extractor_unit.sv =====
// EMG feature extractor, top level. Uses emgfx_pkg, emgfx_ram, emgfx_div, emgfx_zs.
// Taps and the window's samples sit in two RAMs; every feature is rebuilt from them.
//
// Each sample item is stored and then emits the features whose look-ahead has
// arrived; the window-end item flushes the rest. An EMG-mode feature for average
// length W and M taps (M = 1 when no taps) is built by the FIR
// multiply-accumulate loop over the two RAM read ports, followed by a serial
// divide when W > 1. After reset no memory sweep is needed: only samples of the
// current window are read.
module emg_feature_extractor_unit
  import emgfx_pkg::*;
#(
  parameter int MAX_TAPS       = 31,
  parameter int MAX_AVG_LENGTH = 32,
  parameter int MAX_WINDOW     = 512,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SAW  = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int IW   = CW + 8;
  localparam int TAW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int KW   = $clog2(MAX_TAPS + 1);
  localparam int AVW  = $clog2(MAX_AVG_LENGTH + 1);
  localparam int SUMW = FEAT_W + $clog2(MAX_AVG_LENGTH) + 1;
  localparam int PRW  = 17 + SAMPLE_BITS;
  localparam int ACCW = PRW + 6;
  localparam int XW   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RAW   = 4'd2;
  localparam logic [3:0] S_FIR   = 4'd3;
  localparam logic [3:0] S_FDONE = 4'd4;
  localparam logic [3:0] S_EN1   = 4'd5;
  localparam logic [3:0] S_EN2   = 4'd6;
  localparam logic [3:0] S_EN3   = 4'd7;
  localparam logic [3:0] S_NEXTP = 4'd8;
  localparam logic [3:0] S_AVG   = 4'd9;
  localparam logic [3:0] S_AVGW  = 4'd10;
  localparam logic [3:0] S_ZS    = 4'd11;
  localparam logic [3:0] S_ZSW   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam logic signed [IW-1:0] ONE_I = IW'(1);

  logic                     emg_mode;
  logic [4:0]               tap_count;
  logic [5:0]               avg_length;
  logic signed [MEAN_W-1:0] channel_mean;
  logic [ISIG_W-1:0]        inverse_sigma;

  logic [3:0]               state;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            emitted;
  logic                     last_r;
  logic [RES_W-1:0]         nres;
  logic signed [IW-1:0]     p;
  logic signed [IW-1:0]     jlo;
  logic signed [IW-1:0]     jhi;
  logic [KW-1:0]            k;
  logic                     a_on;
  logic                     a_v;
  logic                     b_on;
  logic signed [PRW-1:0]    prod;
  logic signed [ACCW-1:0]   acc;
  logic signed [FILT_W-1:0] f0;
  logic signed [FILT_W-1:0] f1;
  logic signed [FILT_W-1:0] f2;
  logic                     c0;
  logic                     c1;
  logic                     c2;
  logic signed [47:0]       e1;
  logic signed [47:0]       e2;
  logic signed [SUMW-1:0]   s;
  logic                     clip_acc;
  logic signed [FEAT_W-1:0] feat;

  logic [KW-1:0]            m_eff;
  logic [KW-1:0]            mm;
  logic [KW-1:0]            fh;
  logic [AVW-1:0]           w_eff;
  logic [AVW-1:0]           half;
  logic signed [IW-1:0]     ns;
  logic signed [IW-1:0]     ts;
  logic signed [IW-1:0]     ls;
  logic signed [IW-1:0]     jlo_c;
  logic signed [IW-1:0]     jhi_c;
  logic signed [IW-1:0]     xi;
  logic                     xi_ok;
  logic                     issuing;
  logic                     acc_clr;
  logic signed [IW-1:0]     j;
  logic                     ev;
  logic                     more;
  logic signed [ACCW-1:0]   rnd;
  logic signed [ACCW-1:0]   qf;
  logic [ACCW-24:0]         q_top;
  logic                     fir_ovf;
  logic signed [FILT_W-1:0] fir_val;
  logic signed [16:0]       coef;
  logic signed [SAMPLE_BITS-1:0] samp_s;
  logic signed [PRW-1:0]    mul_f;
  logic signed [FILT_W-1:0] ma;
  logic signed [FILT_W-1:0] mb;
  logic signed [47:0]       emul;
  logic                     s_neg;
  logic [SUMW-1:0]          mag;
  logic                     div_start;
  logic                     div_done;
  logic [SUMW-1:0]          quo;
  logic signed [FEAT_W-1:0] qq;
  logic                     zs_start;
  zs_res_t                  zr;

  logic                     req_acc;
  logic                     tap_we;
  logic [TAW-1:0]           tap_waddr;
  logic [TAW-1:0]           tap_raddr;
  logic [15:0]              tap_rdata;
  logic                     smp_we;
  logic [XW-1:0]            smp_x;
  logic [SAW-1:0]           smp_raddr;
  logic [SAMPLE_BITS-1:0]   smp_rdata;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;

  assign m_eff = (32'(tap_count) > MAX_TAPS) ? KW'(MAX_TAPS) : KW'(tap_count);
  assign mm    = (m_eff == '0) ? KW'(1) : m_eff;
  assign fh    = (mm - KW'(1)) >> 1;
  assign w_eff = (avg_length == '0) ? AVW'(1) :
                 ((32'(avg_length) > MAX_AVG_LENGTH) ? AVW'(MAX_AVG_LENGTH) : AVW'(avg_length));
  assign half  = w_eff >> 1;

  assign ns    = $signed(IW'(cnt));
  assign ts    = $signed(IW'(emitted));
  assign ls    = emg_mode ? ($signed(IW'(fh)) + $signed(IW'(w_eff)) - $signed(IW'(half)))
                          : '0;
  assign jlo_c = ts - $signed(IW'(half));
  assign jhi_c = ts + $signed(IW'(w_eff)) - $signed(IW'(half)) - ONE_I;
  assign more  = (last_r ? (ts < ns) : (ts + ls < ns)) && (nres < RES_W'(MAX_RESULTS));

  assign xi      = p - $signed(IW'(k)) + $signed(IW'(fh));
  assign xi_ok   = (xi >= '0) && (xi < ns);
  assign issuing = (state == S_FIR) && (k < mm);
  assign acc_clr = (state == S_CHECK) || (state == S_NEXTP);

  assign j  = p - ONE_I;
  assign ev = (ns > ONE_I) && (j >= ONE_I) && (j <= ns - IW'(2));

  assign coef   = (m_eff == '0) ? 17'sd32768 : {tap_rdata[15], tap_rdata};
  assign samp_s = smp_rdata;
  assign mul_f  = coef * samp_s;

  assign rnd     = acc + ACCW'(16384);
  assign qf      = rnd >>> 15;
  assign q_top   = qf[ACCW-1:23];
  assign fir_ovf = !((&q_top) || (~|q_top));
  assign fir_val = fir_ovf ? (qf[ACCW-1] ? 24'sh800000 : 24'sh7FFFFF) : qf[FILT_W-1:0];

  assign ma   = (state == S_EN1) ? f1 : f0;
  assign mb   = (state == S_EN1) ? f1 : f2;
  assign emul = ma * mb;

  assign s_neg     = s[SUMW-1];
  assign mag       = s_neg ? SUMW'(-s) : SUMW'(s);
  assign div_start = (state == S_AVG) && (w_eff != AVW'(1));
  assign qq        = quo[FEAT_W-1:0];
  assign zs_start  = (state == S_ZS);

  assign smp_x     = XW'(req.sample_value);
  assign smp_we    = req_acc && (req.req_type == REQ_SAMPLE);
  assign tap_we    = req_acc && (req.req_type == REQ_TAP) && (32'(req.tap_index) < MAX_TAPS);
  assign tap_waddr = TAW'(req.tap_index);
  assign tap_raddr = k[TAW-1:0];
  assign smp_raddr = (state == S_FIR) ? xi[SAW-1:0] : emitted[SAW-1:0];

  emgfx_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (req.tap_value),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  emgfx_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (cnt[SAW-1:0]),
    .wdata (smp_x[SAMPLE_BITS-1:0]),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  emgfx_div #(.NW(SUMW), .DW(AVW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mag + SUMW'(half)),
    .den   (w_eff),
    .done  (div_done),
    .quo   (quo)
  );

  emgfx_zs u_zs (
    .clk   (clk),
    .rst   (rst),
    .start (zs_start),
    .feat  (feat),
    .mean  (channel_mean),
    .isig  (inverse_sigma),
    .res   (zr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      emg_mode      <= 1'b1;
      tap_count     <= '0;
      avg_length    <= 6'd1;
      channel_mean  <= '0;
      inverse_sigma <= 48'h1_0000_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EMG_MODE:      emg_mode      <= cfg_data[0];
        CFG_TAP_COUNT:     tap_count     <= cfg_data[4:0];
        CFG_AVG_LENGTH:    avg_length    <= cfg_data[5:0];
        CFG_CHANNEL_MEAN:  channel_mean  <= cfg_data[MEAN_W-1:0];
        CFG_INVERSE_SIGMA: inverse_sigma <= cfg_data[ISIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_on <= 1'b0;
      a_v  <= 1'b0;
      b_on <= 1'b0;
    end else begin
      a_on <= issuing;
      a_v  <= issuing && xi_ok;
      b_on <= a_on;
    end
    prod <= a_v ? mul_f : '0;
    if (b_on) begin
      acc <= acc + ACCW'(prod);
    end else if (acc_clr) begin
      acc <= '0;
    end
    if (issuing) begin
      k <= k + KW'(1);
    end else if (acc_clr) begin
      k <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      emitted   <= '0;
      last_r    <= 1'b0;
      nres      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (smp_we) begin
            cnt    <= cnt + CW'(1);
            last_r <= req.window_end || (32'(cnt) + 1 >= MAX_WINDOW);
            nres   <= '0;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          clip_acc <= 1'b0;
          if (!more) begin
            if (last_r) begin
              cnt     <= '0;
              emitted <= '0;
            end
            state <= S_IDLE;
          end else if (!emg_mode) begin
            state <= S_RAW;
          end else begin
            jlo   <= jlo_c;
            jhi   <= jhi_c;
            p     <= jlo_c - ONE_I;
            s     <= '0;
            state <= S_FIR;
          end
        end
        S_RAW: begin
          feat  <= FEAT_W'(samp_s);
          state <= S_ZS;
        end
        S_FIR: begin
          if (k == mm && !a_on && !b_on) begin
            state <= S_FDONE;
          end
        end
        S_FDONE: begin
          f0 <= f1;
          f1 <= f2;
          f2 <= fir_val;
          c0 <= c1;
          c1 <= c2;
          c2 <= fir_ovf;
          state <= (p > jlo) ? S_EN1 : S_NEXTP;
        end
        S_EN1: begin
          e1    <= emul;
          state <= ev ? S_EN2 : S_NEXTP;
        end
        S_EN2: begin
          e2    <= emul;
          state <= S_EN3;
        end
        S_EN3: begin
          s        <= s + SUMW'(e1) - SUMW'(e2);
          clip_acc <= clip_acc | c0 | c1 | c2;
          state    <= S_NEXTP;
        end
        S_NEXTP: begin
          if (p == jhi + ONE_I) begin
            state <= S_AVG;
          end else begin
            p     <= p + ONE_I;
            state <= S_FIR;
          end
        end
        S_AVG: begin
          if (w_eff == AVW'(1)) begin
            feat  <= FEAT_W'(s);
            state <= S_ZS;
          end else begin
            state <= S_AVGW;
          end
        end
        S_AVGW: begin
          if (div_done) begin
            feat  <= s_neg ? -qq : qq;
            state <= S_ZS;
          end
        end
        S_ZS: begin
          state <= S_ZSW;
        end
        S_ZSW: begin
          if (zr.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res.zscore <= zr.z;
            res.run_last <= last_r && (emitted == cnt - CW'(1));
            res.clipped <= clip_acc | zr.clip;
            res_valid <= 1'b1;
            emitted   <= emitted + CW'(1);
            nres      <= nres + RES_W'(1);
            state     <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emitted <= cnt)
    else $error("feature index ran past the stored samples");

  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (nres < RES_W'(MAX_RESULTS)))
    else $error("result cap exceeded for one item");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_AVGW))
    else $error("divider finished outside the average step");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for emg_feature_extractor_unit: directed and random sample and tap
// items, checked against a scoreboard that predicts every feature. Uses emgfx_pkg.
// Config writes happen only while the block is idle.
module tb;
  import emgfx_pkg::*;

  localparam int WIN_MAX   = 512;
  localparam int IDLE_WAIT = 1600;
  localparam int WDOG_MAX  = 20000;

  class feature_scoreboard;
    bit                 mode;
    logic [4:0]         taps_used;
    logic [5:0]         avg_len;
    logic signed [48:0] mean;
    logic [47:0]        isig;
    logic signed [15:0] coef [31];
    logic signed [15:0] hist [WIN_MAX];
    int                 count;
    int                 emitted;
    bit                 clip_flag;
    res_t               want [$];
    int                 errors;

    function new();
      mode = 1;
      taps_used = 0;
      avg_len = 1;
      mean = 0;
      isig = 48'h1_0000_0000;
      count = 0;
      emitted = 0;
      errors = 0;
      foreach (coef[i]) coef[i] = 0;
      foreach (hist[i]) hist[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_EMG_MODE:      mode = d[0];
        CFG_TAP_COUNT:     taps_used = d[4:0];
        CFG_AVG_LENGTH:    avg_len = d[5:0];
        CFG_CHANNEL_MEAN:  mean = d[48:0];
        CFG_INVERSE_SIGMA: isig = d[47:0];
        default: ;
      endcase
    endfunction

    function int avg_eff();
      if (avg_len == 0) return 1;
      if (avg_len > 32) return 32;
      return int'(avg_len);
    endfunction

    function longint fir_at(int i, int n, int m);
      longint acc;
      longint q;
      int fh;
      int xi;
      if (m == 0) return longint'(hist[i]);
      acc = 0;
      fh = (m - 1) / 2;
      for (int k = 0; k < m; k++) begin
        xi = i - k + fh;
        if (xi >= 0 && xi < n) acc += longint'(coef[k]) * longint'(hist[xi]);
      end
      acc += 16384;
      q = (acc >= 0) ? (acc >>> 15) : -(((-acc) + 32767) >>> 15);
      if (q > 8388607) begin
        clip_flag = 1;
        q = 8388607;
      end
      if (q < -8388608) begin
        clip_flag = 1;
        q = -8388608;
      end
      return q;
    endfunction

    function longint teager_at(int i, int n, int m);
      longint a, b, c;
      if (n <= 1 || i <= 0 || i >= n - 1) return 0;
      a = fir_at(i - 1, n, m);
      b = fir_at(i, n, m);
      c = fir_at(i + 1, n, m);
      return b * b - a * c;
    endfunction

    function longint feature_at(int t, int n);
      int m, w, half;
      longint s, mag;
      if (!mode) return longint'(hist[t]);
      m = int'(taps_used);
      w = avg_eff();
      if (w <= 1) return teager_at(t, n, m);
      half = w / 2;
      s = 0;
      for (int j = t - half; j <= t + (w - half - 1); j++)
        if (j >= 0 && j < n) s += teager_at(j, n, m);
      mag = (s < 0) ? -s : s;
      mag = (mag + w / 2) / w;
      return (s < 0) ? -mag : mag;
    endfunction

    function logic [31:0] zscore_of(longint f);
      longint d;
      bit neg;
      logic [127:0] a, p, q, lim;
      d = f - longint'(mean);
      neg = d < 0;
      a = 128'(neg ? -d : d);
      p = a * {80'b0, isig};
      p = p + 128'd32768;
      q = p >> 16;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        clip_flag = 1;
        q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void push_feature(int t, int n, bit last);
      res_t e;
      clip_flag = 0;
      e.zscore = zscore_of(feature_at(t, n));
      e.run_last = last;
      e.clipped = clip_flag;
      want.push_back(e);
    endfunction

    function int lookahead();
      int m, w;
      if (!mode) return 0;
      m = int'(taps_used);
      w = avg_eff();
      return (m > 0 ? (m - 1) / 2 : 0) + 1 + (w - w / 2 - 1);
    endfunction

    function void note_item(req_t r);
      int n;
      if (r.req_type == REQ_TAP) begin
        if (r.tap_index < 31) coef[r.tap_index] = r.tap_value;
        return;
      end
      if (count >= WIN_MAX) begin
        count = 0;
        emitted = 0;
      end
      hist[count] = r.sample_value;
      count++;
      n = count;
      if (r.window_end || count >= WIN_MAX) begin
        while (emitted < n) begin
          push_feature(emitted, n, emitted == n - 1);
          emitted++;
        end
        count = 0;
        emitted = 0;
        return;
      end
      while (emitted + lookahead() < n) begin
        push_feature(emitted, n, 0);
        emitted++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (want.size() == 0) begin
        $error("unexpected result zscore %0d", got.zscore);
        errors++;
        return;
      end
      e = want.pop_front();
      if (got.zscore !== e.zscore) begin
        $error("zscore expected %0d actual %0d", e.zscore, got.zscore);
        errors++;
      end
      if (got.run_last !== e.run_last) begin
        $error("run_last expected %0b actual %0b", e.run_last, got.run_last);
        errors++;
      end
      if (got.clipped !== e.clipped) begin
        $error("clipped expected %0b actual %0b", e.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  req_valid = 0;
  logic                  req_stall;
  req_t                  req = '0;
  logic                  res_valid;
  logic                  res_stall = 0;
  res_t                  res;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  feature_scoreboard sb = new();
  bit   hold_off = 0;
  bit   busy_gaps = 1;
  int   quiet = 0;
  int   sample_items = 0;

  emg_feature_extractor_unit uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  always @(posedge clk) begin
    if (!rst && ((req_valid && !req_stall) || (res_valid && !res_stall) ||
                 (cfg_valid && cfg_ready)))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG_MAX) begin
      $display("emg_feature_extractor_unit regression: fail");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!busy_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  initial begin
    int k;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        res_stall <= 1;
        repeat (3000) @(posedge clk);
        res_stall <= 0;
        hold_off = 0;
      end else begin
        k = pick_gap();
        if (k > 0) begin
          res_stall <= 1;
          repeat (k) @(posedge clk);
          res_stall <= 0;
        end
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_item(req_t r);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sb.note_item(r);
    if (r.req_type == REQ_SAMPLE) sample_items++;
  endtask

  task automatic send_sample(logic signed [15:0] v, bit last);
    req_t r;
    r = '0;
    r.req_type = REQ_SAMPLE;
    r.sample_value = v;
    r.window_end = last;
    r.tap_index = 5'($urandom);
    r.tap_value = 16'($urandom);
    send_item(r);
  endtask

  task automatic send_tap(logic [4:0] idx, logic signed [15:0] v);
    req_t r;
    r = '0;
    r.req_type = REQ_TAP;
    r.tap_index = idx;
    r.tap_value = v;
    r.sample_value = 16'($urandom);
    r.window_end = 1'($urandom);
    send_item(r);
  endtask

  task automatic wait_idle();
    req_valid <= 0;
    while (sb.want.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_all(bit m, int taps, int avg, longint mu, longint is);
    write_reg(CFG_EMG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_TAP_COUNT, CFG_DATA_W'(taps));
    write_reg(CFG_AVG_LENGTH, CFG_DATA_W'(avg));
    write_reg(CFG_CHANNEL_MEAN, CFG_DATA_W'(mu));
    write_reg(CFG_INVERSE_SIGMA, CFG_DATA_W'(is));
  endtask

  function logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic random_config();
    longint mu, is;
    int r;
    r = $urandom_range(0, 9);
    mu = (r == 0) ? longint'(49'h0_ffff_ffff_ffff) : (r == 1) ? -(longint'(1) <<< 48) :
         longint'($urandom_range(0, 20000)) - 10000;
    r = $urandom_range(0, 9);
    is = (r == 0) ? 0 : (r == 1) ? longint'(48'hffff_ffff_ffff) :
         longint'($urandom_range(1, 1 << 20)) << $urandom_range(8, 24);
    set_all($urandom_range(0, 3) != 0, $urandom_range(0, 31),
            ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8), mu, is);
  endtask

  initial begin
    int len;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_sample(16'sh7fff, 0);
    send_sample(16'sh8000, 0);
    send_sample(0, 0);
    send_sample(1, 0);
    send_sample(-1, 1);
    for (int i = 0; i < 31; i++) send_tap(5'(i), 16'($urandom));
    send_tap(5'd31, 16'sh7fff);
    send_tap(5'd0, 16'sh7fff);
    send_tap(5'd30, 16'sh8000);
    send_sample(1234, 1);
    wait_idle();

    set_all(0, 0, 1, 0, longint'(1) << 32);
    send_sample(16'sh7fff, 0);
    send_sample(16'sh8000, 1);
    wait_idle();
    set_all(0, 31, 32, longint'(49'h0_ffff_ffff_ffff), longint'(48'hffff_ffff_ffff));
    send_sample(16'sh8000, 0);
    send_sample(16'sh7fff, 1);
    wait_idle();
    set_all(1, 31, 32, -(longint'(1) <<< 48), 0);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 3);
    wait_idle();
    set_all(1, 31, 0, 0, longint'(1) << 20);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 3);
    wait_idle();
    set_all(1, 1, 63, 100, longint'(1) << 24);
    for (int i = 0; i < 3; i++) send_sample(rand_sample(), i == 2);
    wait_idle();
    set_all(1, 4, 8, 0, longint'(1) << 24);
    for (int i = 0; i < 8; i++) send_sample(rand_sample(), 0);
    wait_idle();
    write_reg(CFG_AVG_LENGTH, CFG_DATA_W'(1));
    write_reg(CFG_TAP_COUNT, CFG_DATA_W'(0));
    send_sample(rand_sample(), 1);

    hold_off = 1;
    while (sample_items < 60) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        random_config();
      end
      busy_gaps = $urandom_range(0, 3) != 0;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) send_tap(5'($urandom), 16'($urandom));
        if (i > 0 && $urandom_range(0, 19) == 0) begin
          wait_idle();
          write_reg(CFG_AVG_LENGTH, CFG_DATA_W'($urandom_range(0, 6)));
          write_reg(CFG_TAP_COUNT, CFG_DATA_W'($urandom_range(0, 31)));
        end
        send_sample(rand_sample(), i == len - 1);
      end
    end

    req_valid <= 0;
    while (sb.want.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    if (sb.errors == 0)
      $display("emg_feature_extractor_unit regression: pass");
    else
      $display("emg_feature_extractor_unit regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/emgfx_pkg.sv
rtl/emgfx_ram.sv
rtl/emgfx_div.sv
rtl/emgfx_zs.sv
rtl/emg_feature_extractor_unit.sv
test/tb.sv
